/* hdl/taq_pkg.sv */
`timescale 1ns / 1ps

package taq_pkg;

    localparam int PERIOD_W  = 16;
    localparam int DELAY_W   = 16;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 3'd4;

    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CUMUL  = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

endpackage

/* hdl/taq_sermul.sv */
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle.
// Signed multiplicand, unsigned multiplier.
module taq_sermul import taq_pkg::*; #(
    parameter int A_W = 16,
    parameter int B_W = 16,
    localparam int P_W   = A_W + B_W,
    localparam int CNT_W = $clog2(B_W + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [A_W-1:0] i_a,
    input  logic        [B_W-1:0] i_b,
    output logic                  o_done,
    output logic signed [P_W-1:0] o_prod
);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic signed [P_W-1:0] r_acc;
    logic signed [P_W-1:0] r_a_sh;
    logic [B_W-1:0]        r_b_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc  <= '0;
            r_a_sh <= P_W'(i_a);
            r_b_sh <= i_b;
        end else if (r_busy) begin
            r_acc  <= r_acc + (r_b_sh[0] ? r_a_sh : P_W'(0));
            r_a_sh <= r_a_sh <<< 1;
            r_b_sh <= r_b_sh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

/* hdl/taq_serdiv.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// Requires dividend >> Q_W to be below the divisor.
module taq_serdiv import taq_pkg::*; #(
    parameter int DVD_W = 33,
    parameter int DVS_W = 16,
    parameter int Q_W   = 16,
    localparam int CNT_W = $clog2(Q_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [Q_W-1:0]   r_q;
    logic [DVS_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[Q_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DVS_W'(i_dividend >> Q_W);
            r_q   <= i_dividend[Q_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? DVS_W'(w_trial - {1'b0, r_dvs}) : DVS_W'(w_trial);
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* hdl/temperature_alarm_qualifier.sv */
`timescale 1ns / 1ps

// Temperature alarm qualifier.
// Input stream s_axis: one signed Q8.8 temperature sample per transfer.
// Output stream m_axis: one result per sample: latched alarm, running average
// of the current excursion (0 when none) and the excursion sample count.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_wdata, written by the user only
// while idle (the block does not enforce this):
//   0 mode, 1 high limit, 2 low limit, 3 sample period, 4 alarm delay.
// A sample that needs no averaging goes from idle straight to the finish state,
// which loads the output register and raises m_axis_tvalid. An averaging update
// runs first through the bit-serial multipliers, then through the bit-serial
// divider, before the finish state.
// One sample is in flight at a time; s_axis_tready is high only when the
// block is idle. The result sits in an output register, so the next sample
// is taken while it waits; if m_axis_tready stays low, processing of that
// next sample stalls before its result is written.
// Reset (synchronous, active low) clears the alarm, count and average and
// restores register defaults.
module temperature_alarm_qualifier import taq_pkg::*; #(
    parameter int TEMP_WIDTH  = 16,
    parameter int COUNT_WIDTH = 16,
    localparam int CFG_W = (TEMP_WIDTH > PERIOD_W) ? TEMP_WIDTH : PERIOD_W,
    localparam int IN_W  = ((TEMP_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((1 + TEMP_WIDTH + COUNT_WIDTH + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,  // temperature
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata   // alarm, average, excursion_count
);

    localparam int PA_W  = TEMP_WIDTH + COUNT_WIDTH;
    localparam int PB_W  = PERIOD_W + 1 + COUNT_WIDTH;
    localparam int NUM_W = TEMP_WIDTH + COUNT_WIDTH + 1;

    t_state                        r_state;
    logic [MODE_W-1:0]             r_mode;
    logic signed [TEMP_WIDTH-1:0]  r_high;
    logic signed [TEMP_WIDTH-1:0]  r_low;
    logic [PERIOD_W-1:0]           r_period;
    logic [DELAY_W-1:0]            r_delay;

    logic [COUNT_WIDTH-1:0]        r_count;
    logic signed [TEMP_WIDTH-1:0]  r_avg;
    logic                          r_alarm;

    logic [COUNT_WIDTH-1:0]        r_n;
    logic signed [TEMP_WIDTH-1:0]  r_t;
    logic                          r_neg;
    logic                          r_test;

    logic                          r_out_valid;
    logic [OUT_W-1:0]              r_out_data;

    logic                          w_accept;
    logic signed [TEMP_WIDTH-1:0]  w_t;
    logic                          w_t_oor;
    logic [COUNT_WIDTH-1:0]        w_n;
    logic                          w_long;
    logic                          w_mul_start;
    logic                          w_mul_a_done;
    logic                          w_mul_b_done;
    logic signed [PA_W-1:0]        w_prod_a;
    logic signed [PB_W-1:0]        w_prod_b;
    logic signed [NUM_W-1:0]       w_num;
    logic [NUM_W-1:0]              w_mag;
    logic                          w_div_start;
    logic                          w_div_done;
    logic [TEMP_WIDTH-1:0]         w_quot;
    logic signed [TEMP_WIDTH-1:0]  w_avg_new;
    logic                          w_avg_oor;
    logic                          w_out_free;
    logic                          w_out_load;
    logic signed [TEMP_WIDTH-1:0]  w_avg_out;

    function automatic logic out_of_range(
        input logic signed [TEMP_WIDTH-1:0] v,
        input logic signed [TEMP_WIDTH-1:0] hi,
        input logic signed [TEMP_WIDTH-1:0] lo
    );
        return (v > hi) || (v < lo);
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_t           = s_axis_tdata[TEMP_WIDTH-1:0];
    assign w_t_oor       = out_of_range(w_t, r_high, r_low);
    assign w_n           = (r_count == {COUNT_WIDTH{1'b1}}) ? r_count
                                                           : r_count + COUNT_WIDTH'(1);
    assign w_long        = (r_mode == MODE_CUMUL) && (r_count != '0);
    assign w_mul_start   = w_accept && w_long;

    taq_sermul #(
        .A_W(TEMP_WIDTH),
        .B_W(COUNT_WIDTH)
    ) u_mul_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (r_avg),
        .i_b     (w_n - COUNT_WIDTH'(1)),
        .o_done  (w_mul_a_done),
        .o_prod  (w_prod_a)
    );

    taq_sermul #(
        .A_W(PERIOD_W + 1),
        .B_W(COUNT_WIDTH)
    ) u_mul_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     ($signed({1'b0, r_period})),
        .i_b     (w_n),
        .o_done  (w_mul_b_done),
        .o_prod  (w_prod_b)
    );

    assign w_num       = NUM_W'(w_prod_a) + NUM_W'(r_t);
    assign w_mag       = w_num[NUM_W-1] ? NUM_W'(-w_num) : NUM_W'(w_num);
    assign w_div_start = (r_state == ST_MUL) && w_mul_a_done && w_mul_b_done;

    taq_serdiv #(
        .DVD_W(NUM_W),
        .DVS_W(COUNT_WIDTH),
        .Q_W  (TEMP_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_avg_new  = r_neg ? $signed(-w_quot) : $signed(w_quot);
    assign w_avg_oor  = out_of_range(w_avg_new, r_high, r_low);
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_out_load = (r_state == ST_FIN) && w_out_free;
    assign w_avg_out  = (r_count != '0) ? r_avg : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_OFF;
            r_high   <= TEMP_WIDTH'(32'sd32767);
            r_low    <= TEMP_WIDTH'(-32'sd32768);
            r_period <= PERIOD_RST;
            r_delay  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:   r_mode   <= i_cfg_wdata[MODE_W-1:0];
                REG_HIGH:   r_high   <= i_cfg_wdata[TEMP_WIDTH-1:0];
                REG_LOW:    r_low    <= i_cfg_wdata[TEMP_WIDTH-1:0];
                REG_PERIOD: r_period <= i_cfg_wdata[PERIOD_W-1:0];
                REG_DELAY:  r_delay  <= i_cfg_wdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_avg       <= '0;
            r_alarm     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= w_long ? ST_MUL : ST_FIN;
                        case (r_mode)
                            MODE_SINGLE: begin
                                if (w_t_oor) begin
                                    r_alarm <= 1'b1;
                                end
                            end
                            MODE_CUMUL: begin
                                if (r_count == '0 && w_t_oor) begin
                                    r_count <= COUNT_WIDTH'(1);
                                    r_avg   <= w_t;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL: begin
                    if (w_div_start) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_FIN;
                        r_avg   <= w_avg_new;
                        if (r_test && w_avg_oor) begin
                            r_alarm <= 1'b1;
                        end
                        r_count <= (r_test && !w_avg_oor) ? '0 : r_n;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_start) begin
            r_n <= w_n;
            r_t <= w_t;
        end
        if (w_div_start) begin
            r_neg  <= w_num[NUM_W-1];
            r_test <= $unsigned(w_prod_b) > PB_W'(r_delay);
        end
        if (w_out_load) begin
            r_out_data <= OUT_W'({r_count, w_avg_out, r_alarm});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

/* hdl/taq_checker.sv */
`timescale 1ns / 1ps

module taq_checker import taq_pkg::*; #(
    parameter int TEMP_WIDTH  = 16,
    parameter int COUNT_WIDTH = 16,
    localparam int CFG_W = (TEMP_WIDTH > PERIOD_W) ? TEMP_WIDTH : PERIOD_W,
    localparam int OUT_W = ((1 + TEMP_WIDTH + COUNT_WIDTH + 7) / 8) * 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [CFG_W-1:0]     i_cfg_wdata,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [OUT_W-1:0]     m_axis_tdata
);

    localparam int AVG_LO = 1;
    localparam int AVG_HI = TEMP_WIDTH;
    localparam int CNT_LO = TEMP_WIDTH + 1;
    localparam int CNT_HI = TEMP_WIDTH + COUNT_WIDTH;

    // one sample in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    // alarm is sticky
    a_alarm_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |=> (!m_axis_tvalid || m_axis_tdata[0]))
        else $error("alarm dropped without reset");

    // no excursion means average reads zero
    a_idle_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[CNT_HI:CNT_LO] == '0)
            |-> (m_axis_tdata[AVG_HI:AVG_LO] == '0))
        else $error("nonzero average with zero count");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output changed while stalled");

    // register writes only while the block is empty
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> (s_axis_tready && !m_axis_tvalid
                      && !$isunknown({i_cfg_idx, i_cfg_wdata})))
        else $error("register write while busy");

endmodule

bind temperature_alarm_qualifier taq_checker #(
    .TEMP_WIDTH (TEMP_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
) u_taq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx),
    .i_cfg_wdata   (i_cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* test/temperature_alarm_qualifier_tb.sv */
`timescale 1ns / 1ps

module temperature_alarm_qualifier_tb;
    import taq_pkg::*;

    localparam logic [MODE_W-1:0]    MODE_RSVD = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE  = 3'd5;

    typedef struct packed {
        logic               alarm;
        logic signed [15:0] average;
        logic [15:0]        excursion_count;
    } t_qual_result;

    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          value;
        logic                 known;
        t_qual_result         want;
    } t_step;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [15:0]          i_cfg_wdata = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata = '0;   // temperature
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;        // alarm, average, excursion_count

    temperature_alarm_qualifier u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // configuration shadow
    logic [MODE_W-1:0]  cfg_mode = MODE_OFF;
    logic signed [15:0] cfg_high = 16'sh7FFF;
    logic signed [15:0] cfg_low = 16'sh8000;
    logic [15:0]        cfg_period = PERIOD_RST;
    logic [15:0]        cfg_delay = '0;

    // excursion tracking
    logic [15:0]        exc_count = '0;
    logic signed [15:0] exc_avg = '0;
    logic               alarm_held = 1'b0;

    t_qual_result pending_results[$];
    int           fault_count = 0;
    int           src_idle_pct = 38;
    int           snk_idle_pct = 66;
    t_step        plan [0:23];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("temperature_alarm_qualifier: mismatch");
        $finish;
    end

    function automatic bit beyond_limits(input logic signed [15:0] v);
        return v > cfg_high || v < cfg_low;
    endfunction

    function automatic t_qual_result qualify_sample(input logic signed [15:0] temp);
        t_qual_result r;
        longint n;
        longint acc;
        longint quot;
        if (cfg_mode == MODE_SINGLE) begin
            if (beyond_limits(temp))
                alarm_held = 1'b1;
        end else if (cfg_mode == MODE_CUMUL) begin
            if (exc_count == 0) begin
                if (beyond_limits(temp)) begin
                    exc_count = 16'd1;
                    exc_avg = temp;
                end
            end else begin
                if (exc_count != 16'hFFFF)
                    exc_count = exc_count + 16'd1;
                n = exc_count;
                acc = longint'(exc_avg) * (n - 1) + longint'(temp);
                quot = acc / n;
                exc_avg = quot[15:0];
                if (n * cfg_period > cfg_delay) begin
                    if (beyond_limits(exc_avg))
                        alarm_held = 1'b1;
                    else
                        exc_count = '0;
                end
            end
        end
        r.alarm = alarm_held;
        r.average = (exc_count != 0) ? exc_avg : 16'sd0;
        r.excursion_count = exc_count;
        return r;
    endfunction

    function automatic logic [15:0] clamp_q88(input int v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_temp();
        int r;
        logic [31:0] raw;
        r = $urandom_range(0, 9);
        raw = $urandom();
        if (r == 0)
            return raw[15:0];
        if (r == 1)
            return raw[0] ? 16'h7FFF : 16'h8000;
        if (r < 6)
            return clamp_q88(int'(cfg_high) + int'($urandom_range(0, 128)) - 64);
        return clamp_q88(int'(cfg_low) + int'($urandom_range(0, 128)) - 64);
    endfunction

    function automatic t_step wr(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
        t_step s;
        s = '0;
        s.is_write = 1'b1;
        s.idx = idx;
        s.value = v;
        return s;
    endfunction

    function automatic t_step feed(input logic [15:0] v);
        t_step s;
        s = '0;
        s.value = v;
        return s;
    endfunction

    function automatic t_step feed_known(input logic [15:0] v, input logic a,
                                         input logic [15:0] avg, input logic [15:0] cnt);
        t_step s;
        s = feed(v);
        s.known = 1'b1;
        s.want.alarm = a;
        s.want.average = avg;
        s.want.excursion_count = cnt;
        return s;
    endfunction

    task automatic note_fault(input string field, input longint want, input longint got);
        fault_count++;
        $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
    endtask

    // called only right after a rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_MODE:   cfg_mode = val[MODE_W-1:0];
            REG_HIGH:   cfg_high = val;
            REG_LOW:    cfg_low = val;
            REG_PERIOD: cfg_period = val;
            REG_DELAY:  cfg_delay = val;
            default: ;
        endcase
    endtask

    task automatic send_temp(input logic [15:0] temp, input logic known,
                             input t_qual_result want);
        t_qual_result predicted;
        i_cfg_we <= 1'b0;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= temp;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = qualify_sample(temp);
        pending_results.push_back(known ? want : predicted);
    endtask

    // block idle: every result back and input side ready
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic retune();
        int pick;
        int c;
        int w;
        int hi;
        int lo;
        if ($urandom_range(0, 1)) begin
            pick = $urandom_range(0, 9);
            write_reg(REG_MODE, 16'(pick == 0 ? MODE_OFF : pick == 1 ? MODE_RSVD :
                                    pick < 4 ? MODE_SINGLE : MODE_CUMUL));
        end
        if ($urandom_range(0, 1)) begin
            pick = $urandom_range(0, 5);
            c = int'($urandom_range(0, 65535)) - 32768;
            if (pick == 0) begin
                hi = 32767;
                lo = -32768;
            end else if (pick == 1) begin
                hi = c;
                lo = c + int'($urandom_range(1, 500));
            end else begin
                w = $urandom_range(0, 3000);
                hi = c + w;
                lo = c - w;
            end
            write_reg(REG_HIGH, clamp_q88(hi));
            write_reg(REG_LOW, clamp_q88(lo));
        end
        if ($urandom_range(0, 1)) begin
            pick = $urandom_range(0, 5);
            write_reg(REG_PERIOD, pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF :
                                  16'($urandom_range(1, 8)));
        end
        if ($urandom_range(0, 1)) begin
            pick = $urandom_range(0, 5);
            write_reg(REG_DELAY, pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF :
                                 16'($urandom_range(0, 40)));
        end
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_NONE + 3'($urandom_range(0, 2)), 16'($urandom()));
    endtask

    always @(posedge i_clk) begin : result_check
        t_qual_result got;
        t_qual_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.alarm = m_axis_tdata[0];
            got.average = m_axis_tdata[16:1];
            got.excursion_count = m_axis_tdata[32:17];
            if (pending_results.size() == 0) begin
                fault_count++;
                $display("%0t unexpected result: expected none, got %h", $time, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.alarm !== want.alarm)
                    note_fault("alarm", want.alarm, got.alarm);
                if (got.average !== want.average)
                    note_fault("average", $signed(want.average), $signed(got.average));
                if (got.excursion_count !== want.excursion_count)
                    note_fault("excursion_count", want.excursion_count, got.excursion_count);
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    initial begin
        plan = '{
            feed_known(16'h8000, 1'b0, 16'd0, 16'd0),
            feed_known(16'h7FFF, 1'b0, 16'd0, 16'd0),
            wr(REG_MODE, 16'(MODE_RSVD)),
            wr(REG_HIGH, 16'd100),
            wr(REG_LOW, 16'hFF9C),
            feed_known(16'h7FFF, 1'b0, 16'd0, 16'd0),   // reserved mode ignores samples
            wr(REG_DELAY, 16'd4),
            wr(REG_MODE, 16'(MODE_CUMUL)),
            feed_known(16'd200, 1'b0, 16'd200, 16'd1),  // excursion opens
            feed(16'd50),
            feed(16'hFED4),                             // in-range average clears count
            feed_known(16'h8000, 1'b0, 16'h8000, 16'd1),
            wr(REG_MODE, 16'(MODE_OFF)),
            feed_known(16'd0, 1'b0, 16'h8000, 16'd1),   // excursion held
            wr(REG_NONE, 16'd1),                        // unmapped index
            wr(REG_PERIOD, 16'd0),
            wr(REG_MODE, 16'(MODE_CUMUL)),
            feed(16'h7FFF),
            feed(16'hFFFF),
            wr(REG_HIGH, 16'hFF38),                     // low above high
            wr(REG_PERIOD, 16'hFFFF),
            feed(16'hFF6A),
            wr(REG_MODE, 16'(MODE_SINGLE)),
            feed(16'd0)
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_write) begin
                settle();
                write_reg(plan[k].idx, plan[k].value);
            end else begin
                send_temp(plan[k].value, plan[k].known, plan[k].want);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 66 : 0;
            snk_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 38 : 0;
            for (int seg = 0; seg < 10; seg++) begin
                settle();
                retune();
                repeat ($urandom_range(20, 52))
                    send_temp(pick_temp(), 1'b0, '0);
            end
        end

        // long delay: excursion keeps running without a test
        settle();
        write_reg(REG_MODE, 16'(MODE_CUMUL));
        write_reg(REG_HIGH, 16'd0);
        write_reg(REG_LOW, 16'd0);
        write_reg(REG_PERIOD, 16'd1);
        write_reg(REG_DELAY, 16'hFFFE);
        repeat (8)
            send_temp(pick_temp(), 1'b0, '0);

        settle();
        repeat (40) @(posedge i_clk);
        if (fault_count == 0)
            $display("temperature_alarm_qualifier: match");
        else
            $display("temperature_alarm_qualifier: mismatch");
        $finish;
    end

endmodule
